// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL; all are clocked on clock and held off in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds on every clock edge outside reset
`define ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("assertion failed: invariant");

// Consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/oscs_pkg.sv =====
`timescale 1ns / 1ps
package oscs_pkg;

   // Serial multiplier geometry
   localparam int MUL_W     = 16;
   localparam int MUL_CNT_W = $clog2(MUL_W);

   // Frame record limit and counter width (counter must hold the limit itself)
   localparam int MAX_OBSTACLES = 16;
   localparam int CNT_W         = $clog2(MAX_OBSTACLES + 1);

   // Fixed point constants
   localparam logic [15:0] ONE_Q15      = 16'h8000;
   localparam logic [31:0] HALF_Q15     = 32'd16384;
   localparam logic [15:0] SKIP_BELOW   = 16'd4;
   localparam logic [15:0] AUDIBLE_MIN  = 16'd328;
   localparam logic [15:0] HEIGHT_ALPHA = 16'd8192;
   localparam logic [15:0] PITCH_ALPHA  = 16'd8192;
   localparam logic [15:0] HEIGHT_BIAS  = 16'd16384;
   localparam logic [15:0] PITCH_RESET  = 16'd4096;

   // Register indexes (byte address / 4)
   localparam logic [2:0] REG_MIN_CONF    = 3'd0;
   localparam logic [2:0] REG_GAIN_SLOPE  = 3'd1;
   localparam logic [2:0] REG_GAIN_CEIL   = 3'd2;
   localparam logic [2:0] REG_GAIN_ALPHA  = 3'd3;
   localparam logic [2:0] REG_MAG_LOW     = 3'd4;
   localparam logic [2:0] REG_PITCH_SLOPE = 3'd5;
   localparam logic [2:0] REG_PITCH_LOW   = 3'd6;
   localparam logic [2:0] REG_PITCH_HIGH  = 3'd7;

   // Sequencer states
   localparam int          ST_W     = 4;
   localparam logic [3:0]  S_IDLE   = 4'd0;
   localparam logic [3:0]  S_RAW    = 4'd1;
   localparam logic [3:0]  S_GAIN   = 4'd2;
   localparam logic [3:0]  S_LEFT   = 4'd3;
   localparam logic [3:0]  S_RIGHT  = 4'd4;
   localparam logic [3:0]  S_GA1    = 4'd5;
   localparam logic [3:0]  S_GA2    = 4'd6;
   localparam logic [3:0]  S_H1     = 4'd7;
   localparam logic [3:0]  S_H2     = 4'd8;
   localparam logic [3:0]  S_P0     = 4'd9;
   localparam logic [3:0]  S_P1     = 4'd10;
   localparam logic [3:0]  S_P2     = 4'd11;
   localparam logic [3:0]  S_FIN    = 4'd12;

   typedef logic [15:0] word_type;

   // Saturate a Q1.15 quantity at 1.0
   function automatic word_type sat15(input word_type v);
      return (v > ONE_Q15) ? ONE_Q15 : v;
   endfunction

endpackage

// ===== rtl/oscs_serial_mul.sv =====
`timescale 1ns / 1ps
module oscs_serial_mul
   import oscs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [MUL_W-1:0]     op_a,
   input  logic [MUL_W-1:0]     op_b,
   output logic                 done,
   output logic [2*MUL_W-1:0]   product
);

   logic [MUL_W-1:0]     a_ff, a_in;
   logic [MUL_W-1:0]     hi_ff, hi_in;
   logic [MUL_W-1:0]     lo_ff, lo_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MUL_W:0]       sum;

   // Add the multiplicand when the low multiplier bit is set, then shift one bit
   always_comb begin
      sum     = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : '0);
      a_in    = a_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = op_a;
         hi_in   = '0;
         lo_in   = op_b;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         hi_in  = sum[MUL_W:1];
         lo_in  = {sum[0], lo_ff[MUL_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MUL_CNT_W'(MUL_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Hold control in reset; operand and product bits need none
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff  <= a_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};

endmodule

// ===== rtl/obstacle_stereo_cue_smoother_unit.sv =====
// Obstacle stereo cue smoother. Records of one frame arrive on req_*, the final one with
// req_last set; one result carrying the smoothed gain, height and pitch of both sides
// leaves on rsp_* per frame. All products go through one bit-serial 16x16 multiplier,
// and each product is issued to it and then collected from it. A record that is
// inactive or beyond the first 16 of its frame takes no product, a record whose gain falls
// below the skip level takes 2 products, and a contributing record takes 4. A closing
// record adds 4 products per side, 7 when that side is audible, and the result register
// is then loaded once it is free; a new record is taken while an earlier result still
// waits on rsp_ready. Registers sit at byte addresses 4*i on the APB port; the user must
// write them only while the unit is idle, and the unit itself does not enforce this.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module obstacle_stereo_cue_smoother_unit
   import oscs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // record channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_active,
   input  logic [15:0]        req_confidence,
   input  logic [15:0]        req_pos_x,
   input  logic [15:0]        req_pos_y,
   input  logic [15:0]        req_motion_mag,
   input  logic [15:0]        req_suppression,
   input  logic               req_last,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_left_gain,
   output logic signed [15:0] rsp_left_height,
   output logic [15:0]        rsp_left_pitch,
   output logic [15:0]        rsp_right_gain,
   output logic signed [15:0] rsp_right_height,
   output logic [15:0]        rsp_right_pitch,
   // register port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   // Configuration registers
   word_type min_conf_ff, gain_slope_ff, gain_ceil_ff, gain_alpha_ff;
   word_type mag_low_ff, pitch_slope_ff, pitch_low_ff, pitch_high_ff;

   // Latched record
   logic     active_ff, last_ff;
   word_type conf_ff, x_ff, y_ff, mag_ff, supp_ff;

   // Sequencer
   logic [ST_W-1:0]  state_ff, state_in;
   logic             issued_ff, issued_in;
   logic             side_ff, side_in;
   logic [CNT_W-1:0] rec_cnt_ff, rec_cnt_in;
   word_type         tmp_ff, tmp_in;
   logic [31:0]      acc_ff, acc_in;

   // Per-side state; heights are kept with a bias of one half so they stay unsigned
   word_type smooth_gain_ff [2], smooth_gain_in [2];
   word_type smooth_hb_ff   [2], smooth_hb_in   [2];
   word_type smooth_pitch_ff[2], smooth_pitch_in[2];
   word_type best_gain_ff   [2], best_gain_in   [2];
   word_type best_hb_ff     [2], best_hb_in     [2];
   word_type best_mag_ff    [2], best_mag_in    [2];

   // Result register
   logic     rsp_valid_ff, rsp_valid_in;
   word_type out_gain_ff [2];
   word_type out_hb_ff   [2];
   word_type out_pitch_ff[2];

   // Multiplier hookup
   logic        mul_start, mul_done, is_mul_state;
   word_type    mul_a, mul_b;
   logic [31:0] prod;

   // Datapath helpers
   logic        req_take, csr_we, rsp_load;
   word_type    ga, diff, dm, contrib, gval, top, cur_sg;
   logic [31:0] sum;
   logic [28:0] tgt;
   logic [ST_W-1:0] after_rec;

   oscs_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (prod)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_take  = req_valid && req_ready;
   assign csr_we    = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign rsp_load  = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ready);

   // Register reads
   always_comb begin
      unique case (paddr[4:2])
         REG_MIN_CONF:    prdata = {16'd0, min_conf_ff};
         REG_GAIN_SLOPE:  prdata = {16'd0, gain_slope_ff};
         REG_GAIN_CEIL:   prdata = {16'd0, gain_ceil_ff};
         REG_GAIN_ALPHA:  prdata = {16'd0, gain_alpha_ff};
         REG_MAG_LOW:     prdata = {16'd0, mag_low_ff};
         REG_PITCH_SLOPE: prdata = {16'd0, pitch_slope_ff};
         REG_PITCH_LOW:   prdata = {16'd0, pitch_low_ff};
         REG_PITCH_HIGH:  prdata = {16'd0, pitch_high_ff};
         default:         prdata = '0;
      endcase
   end

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         min_conf_ff    <= 16'd0;
         gain_slope_ff  <= 16'd256;
         gain_ceil_ff   <= 16'd32768;
         gain_alpha_ff  <= 16'd8192;
         mag_low_ff     <= 16'd0;
         pitch_slope_ff <= 16'd256;
         pitch_low_ff   <= 16'd2048;
         pitch_high_ff  <= 16'd8192;
      end else if (csr_we) begin
         unique case (paddr[4:2])
            REG_MIN_CONF:    min_conf_ff    <= pwdata[15:0];
            REG_GAIN_SLOPE:  gain_slope_ff  <= pwdata[15:0];
            REG_GAIN_CEIL:   gain_ceil_ff   <= pwdata[15:0];
            REG_GAIN_ALPHA:  gain_alpha_ff  <= pwdata[15:0];
            REG_MAG_LOW:     mag_low_ff     <= pwdata[15:0];
            REG_PITCH_SLOPE: pitch_slope_ff <= pwdata[15:0];
            REG_PITCH_LOW:   pitch_low_ff   <= pwdata[15:0];
            REG_PITCH_HIGH:  pitch_high_ff  <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Latch the record on accept, saturating Q1.15 fields
   always_ff @(posedge clock) begin
      if (req_take) begin
         active_ff <= req_active;
         last_ff   <= req_last;
         conf_ff   <= req_confidence;
         x_ff      <= sat15(req_pos_x);
         y_ff      <= sat15(req_pos_y);
         mag_ff    <= req_motion_mag;
         supp_ff   <= sat15(req_suppression);
      end
   end

   // Operand selection per step
   always_comb begin
      ga   = sat15(gain_alpha_ff);
      diff = (conf_ff > min_conf_ff) ? (conf_ff - min_conf_ff) : '0;
      dm   = (best_mag_ff[side_ff] > mag_low_ff) ? (best_mag_ff[side_ff] - mag_low_ff) : '0;
      unique case (state_ff)
         S_RAW:   begin mul_a = diff;                   mul_b = gain_slope_ff;            end
         S_GAIN:  begin mul_a = tmp_ff;                 mul_b = supp_ff;                  end
         S_LEFT:  begin mul_a = ONE_Q15 - x_ff;         mul_b = tmp_ff;                   end
         S_RIGHT: begin mul_a = x_ff;                   mul_b = tmp_ff;                   end
         S_GA1:   begin mul_a = ga;                     mul_b = best_gain_ff[side_ff];    end
         S_GA2:   begin mul_a = ONE_Q15 - ga;           mul_b = smooth_gain_ff[side_ff];  end
         S_H1:    begin mul_a = HEIGHT_ALPHA;           mul_b = best_hb_ff[side_ff];      end
         S_H2:    begin mul_a = ONE_Q15 - HEIGHT_ALPHA; mul_b = smooth_hb_ff[side_ff];    end
         S_P0:    begin mul_a = dm;                     mul_b = pitch_slope_ff;           end
         S_P1:    begin mul_a = PITCH_ALPHA;            mul_b = tmp_ff;                   end
         S_P2:    begin mul_a = ONE_Q15 - PITCH_ALPHA;  mul_b = smooth_pitch_ff[side_ff]; end
         default: begin mul_a = '0;                     mul_b = '0;                       end
      endcase
      unique case (state_ff) inside
         S_RAW, S_GAIN, S_LEFT, S_RIGHT, S_GA1, S_GA2, S_H1, S_H2, S_P0, S_P1, S_P2:
            is_mul_state = 1'b1;
         default:
            is_mul_state = 1'b0;
      endcase
   end

   assign mul_start = is_mul_state && !issued_ff;

   // Sequencer: issue a product, wait for it, fold it into state
   always_comb begin
      state_in     = state_ff;
      issued_in    = mul_done ? 1'b0 : (mul_start ? 1'b1 : issued_ff);
      side_in      = side_ff;
      rec_cnt_in   = rec_cnt_ff;
      tmp_in       = tmp_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      for (int k = 0; k < 2; k++) begin
         smooth_gain_in[k]  = smooth_gain_ff[k];
         smooth_hb_in[k]    = smooth_hb_ff[k];
         smooth_pitch_in[k] = smooth_pitch_ff[k];
         best_gain_in[k]    = best_gain_ff[k];
         best_hb_in[k]      = best_hb_ff[k];
         best_mag_in[k]     = best_mag_ff[k];
      end

      after_rec = last_ff ? S_GA1 : S_IDLE;
      sum       = acc_ff + prod;
      contrib   = prod[30:15];
      gval      = prod[30:15];
      cur_sg    = smooth_gain_ff[side_ff];
      top       = (pitch_high_ff > pitch_low_ff) ? pitch_high_ff : pitch_low_ff;
      tgt       = {13'd0, pitch_low_ff} + {1'b0, prod[31:4]};

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               side_in = 1'b0;
               if (rec_cnt_ff < CNT_W'(MAX_OBSTACLES)) begin
                  rec_cnt_in = rec_cnt_ff + 1'b1;
               end
               if ((rec_cnt_ff < CNT_W'(MAX_OBSTACLES)) && req_active) begin
                  state_in = S_RAW;
               end else begin
                  state_in = req_last ? S_GA1 : S_IDLE;
               end
            end
         end
         S_RAW: begin
            if (mul_done) begin
               tmp_in   = (prod[31:1] > {15'd0, sat15(gain_ceil_ff)}) ?
                          sat15(gain_ceil_ff) : prod[16:1];
               state_in = S_GAIN;
            end
         end
         S_GAIN: begin
            if (mul_done) begin
               tmp_in   = gval;
               state_in = (gval < SKIP_BELOW) ? after_rec : S_LEFT;
            end
         end
         S_LEFT: begin
            if (mul_done) begin
               if (contrib > best_gain_ff[0]) begin
                  best_gain_in[0] = contrib;
                  best_hb_in[0]   = ONE_Q15 - y_ff;
                  best_mag_in[0]  = mag_ff;
               end
               state_in = S_RIGHT;
            end
         end
         S_RIGHT: begin
            if (mul_done) begin
               if (contrib > best_gain_ff[1]) begin
                  best_gain_in[1] = contrib;
                  best_hb_in[1]   = ONE_Q15 - y_ff;
                  best_mag_in[1]  = mag_ff;
               end
               state_in = after_rec;
            end
         end
         S_GA1: begin
            if (mul_done) begin
               acc_in   = prod + HALF_Q15;
               state_in = S_GA2;
            end
         end
         S_GA2: begin
            if (mul_done) begin
               smooth_gain_in[side_ff] = sum[30:15];
               state_in                = S_H1;
            end
         end
         S_H1: begin
            if (mul_done) begin
               acc_in   = prod + HALF_Q15;
               state_in = S_H2;
            end
         end
         S_H2: begin
            if (mul_done) begin
               smooth_hb_in[side_ff] = sum[30:15];
               if (cur_sg >= AUDIBLE_MIN) begin
                  state_in = S_P0;
               end else if (!side_ff) begin
                  side_in  = 1'b1;
                  state_in = S_GA1;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_P0: begin
            if (mul_done) begin
               tmp_in   = (tgt > {13'd0, top}) ? top : tgt[15:0];
               state_in = S_P1;
            end
         end
         S_P1: begin
            if (mul_done) begin
               acc_in   = prod + HALF_Q15;
               state_in = S_P2;
            end
         end
         S_P2: begin
            if (mul_done) begin
               smooth_pitch_in[side_ff] = sum[30:15];
               if (!side_ff) begin
                  side_in  = 1'b1;
                  state_in = S_GA1;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_FIN: begin
            // Close the frame once the result register is free
            if (rsp_load) begin
               rec_cnt_in = '0;
               for (int k = 0; k < 2; k++) begin
                  best_gain_in[k] = '0;
                  best_mag_in[k]  = '0;
                  best_hb_in[k]   = smooth_hb_ff[k];
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issued_ff    <= 1'b0;
         side_ff      <= 1'b0;
         rec_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 2; k++) begin
            smooth_gain_ff[k]  <= '0;
            smooth_hb_ff[k]    <= HEIGHT_BIAS;
            smooth_pitch_ff[k] <= PITCH_RESET;
            best_gain_ff[k]    <= '0;
            best_hb_ff[k]      <= HEIGHT_BIAS;
            best_mag_ff[k]     <= '0;
         end
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         side_ff      <= side_in;
         rec_cnt_ff   <= rec_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int k = 0; k < 2; k++) begin
            smooth_gain_ff[k]  <= smooth_gain_in[k];
            smooth_hb_ff[k]    <= smooth_hb_in[k];
            smooth_pitch_ff[k] <= smooth_pitch_in[k];
            best_gain_ff[k]    <= best_gain_in[k];
            best_hb_ff[k]      <= best_hb_in[k];
            best_mag_ff[k]     <= best_mag_in[k];
         end
      end
   end

   // Working registers and result payload
   always_ff @(posedge clock) begin
      tmp_ff <= tmp_in;
      acc_ff <= acc_in;
      if (rsp_load) begin
         for (int k = 0; k < 2; k++) begin
            out_gain_ff[k]  <= smooth_gain_ff[k];
            out_hb_ff[k]    <= smooth_hb_ff[k];
            out_pitch_ff[k] <= smooth_pitch_ff[k];
         end
      end
   end

   // Drive the result channel; remove the height bias
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_left_gain    = out_gain_ff[0];
   assign rsp_left_height  = $signed(out_hb_ff[0] - HEIGHT_BIAS);
   assign rsp_left_pitch   = out_pitch_ff[0];
   assign rsp_right_gain   = out_gain_ff[1];
   assign rsp_right_height = $signed(out_hb_ff[1] - HEIGHT_BIAS);
   assign rsp_right_pitch  = out_pitch_ff[1];

   `ASSERT_IMPLIES(a_done_issued, mul_done, issued_ff && is_mul_state)
   `ASSERT_ALWAYS(a_cnt_bound, rec_cnt_ff <= CNT_W'(MAX_OBSTACLES))
   `ASSERT_NEXT(a_fin_clear, rsp_load, rsp_valid_ff && (rec_cnt_ff == '0) && (state_ff == S_IDLE))
   `ASSERT_ALWAYS(a_gain_q15, (smooth_gain_ff[0] <= ONE_Q15) && (smooth_gain_ff[1] <= ONE_Q15))

endmodule
